// ----- design/shbs_pkg.sv -----
package shbs_pkg;

	typedef enum logic [2:0] {
		M_IDLE      = 3'd0,
		M_HOMING    = 3'd1,
		M_PREP      = 3'd2,
		M_UP        = 3'd3,
		M_DOWN_OVER = 3'd4,
		M_DOWN_CORR = 3'd5
	} mode_t;

	typedef enum logic [1:0] {
		OP_TICK = 2'd0,
		OP_HOME = 2'd1,
		OP_MOVE = 2'd2
	} op_t;

	// jump conditions of the microcode
	typedef enum logic [2:0] {
		J_NONE     = 3'd0,
		J_NO_IN    = 3'd1,
		J_NO_TRACK = 3'd2,
		J_DIV_MORE = 3'd3,
		J_OUT_BUSY = 3'd4
	} jump_t;

	localparam int STEP_W = 3;
	typedef logic [STEP_W-1:0] step_t;

	localparam step_t S_WAIT     = 3'd0;
	localparam step_t S_CTRL     = 3'd1;
	localparam step_t S_MUL      = 3'd2;
	localparam step_t S_PREP     = 3'd3;
	localparam step_t S_DIV_INIT = 3'd4;
	localparam step_t S_DIV      = 3'd5;
	localparam step_t S_POS      = 3'd6;
	localparam step_t S_EMIT     = 3'd7;

	typedef struct packed {
		logic  accept;
		logic  ctrl;
		logic  mul;
		logic  prep;
		logic  div_init;
		logic  div_step;
		logic  pos;
		logic  emit;
		jump_t jump;
		step_t dest;
	} ucode_t;

	typedef struct packed {
		logic track;
		logic div_last;
		logic out_busy;
	} dp_status_t;

	localparam int DIV_STEPS = 32;
	localparam logic [11:0] PPM_RESET = 12'd400;
	localparam logic signed [23:0] HOMING_RUN = 24'sd5000000;
	localparam logic signed [23:0] BACKLASH_PULSES = 24'sd820; // dead zone plus overshoot
	localparam logic signed [18:0] HOME_POS_Q8 = 19'sd53760;   // 210 mm
	localparam logic [16:0] HOME_TGT_Q8 = 17'd53760;

endpackage

// ----- design/shbs_ucode_rom.sv -----
module shbs_ucode_rom (
	input  shbs_pkg::step_t  step,
	output shbs_pkg::ucode_t cw
);
	import shbs_pkg::*;

	always_comb begin
		cw = '0;
		cw.jump = J_NONE;
		cw.dest = S_WAIT;
		case (step)
			S_WAIT: begin
				cw.accept = 1'b1;
				cw.jump = J_NO_IN;
				cw.dest = S_WAIT;
			end
			S_CTRL:     cw.ctrl = 1'b1;
			S_MUL:      cw.mul = 1'b1;
			S_PREP: begin
				cw.prep = 1'b1;
				cw.jump = J_NO_TRACK;
				cw.dest = S_EMIT;
			end
			S_DIV_INIT: cw.div_init = 1'b1;
			S_DIV: begin
				cw.div_step = 1'b1;
				cw.jump = J_DIV_MORE;
				cw.dest = S_DIV;
			end
			S_POS:      cw.pos = 1'b1;
			S_EMIT: begin
				cw.emit = 1'b1;
				cw.jump = J_OUT_BUSY;
				cw.dest = S_EMIT;
			end
			default: cw = '0;
		endcase
	end

endmodule

// ----- design/shbs_datapath.sv -----
module shbs_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  shbs_pkg::ucode_t    cw,
	output shbs_pkg::dp_status_t status,
	input  logic                cfg_valid,
	input  logic [11:0]         pulses_per_mm,
	input  logic                in_valid,
	input  logic [1:0]          op,
	input  logic [16:0]         target_position,
	input  logic                switch_pressed,
	input  logic                motor_running,
	input  logic signed [23:0]  distance_to_go,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                move_valid,
	output logic signed [23:0]  move_pulses,
	output logic                stop_request,
	output logic                slow_speed,
	output logic                constant_speed,
	output logic [2:0]          machine_mode,
	output logic signed [18:0]  current_position
);
	import shbs_pkg::*;

	function automatic logic signed [23:0] sat24(input logic signed [33:0] v);
		if (v > 34'sd8388607) return 24'sh7fffff;
		if (v < -34'sd8388608) return 24'sh800000;
		return v[23:0];
	endfunction

	function automatic logic signed [18:0] sat19(input logic signed [33:0] v);
		if (v > 34'sd262143) return 19'sh3ffff;
		if (v < -34'sd262144) return 19'sh40000;
		return v[18:0];
	endfunction

	// architectural state
	mode_t             mode_q;
	logic              p1_q, p2_q, prev_q;
	logic signed [18:0] pos_q;
	logic [16:0]       tgt_q;
	logic [11:0]       ppm_q;

	// latched beat
	logic [1:0]        op_q;
	logic [16:0]       tgt_in_q;
	logic              sw_q, run_q;
	logic signed [23:0] dtg_q;

	// tick scratch
	logic              mv_q, stop_q, prep_q;
	logic signed [23:0] mvp_q;
	logic signed [19:0] d_q;
	logic signed [32:0] prod_q;
	logic [31:0]       dq_q;
	logic [11:0]       rem_q;
	logic              neg_q;
	logic [4:0]        div_cnt_q;

	// result register
	logic              out_valid_q, move_valid_q, stop_out_q, p2_out_q;
	logic signed [23:0] move_pulses_q;
	mode_t             mode_out_q;
	logic signed [18:0] pos_out_q;

	logic [11:0] ppm_e;
	assign ppm_e = (ppm_q == 12'd0) ? 12'd1 : ppm_q;

	// control step
	mode_t             mode_c;
	logic              p1_c, p2_c, mv_c, stop_c, prep_c;
	logic signed [18:0] pos_c;
	logic [16:0]       tgt_c;
	logic signed [23:0] mvp_c;
	logic signed [19:0] d_c;

	always_comb begin
		mode_c = mode_q;
		p1_c = p1_q;
		p2_c = p2_q;
		pos_c = pos_q;
		tgt_c = tgt_q;
		mv_c = 1'b0;
		mvp_c = '0;
		prep_c = 1'b0;
		stop_c = sw_q && !prev_q;
		if (mode_q == M_IDLE) begin
			if (op_q == OP_HOME) begin
				mode_c = M_HOMING;
			end else if (op_q == OP_MOVE) begin
				mode_c = M_PREP;
				tgt_c = tgt_in_q;
			end
		end
		if (mode_c == M_HOMING) begin
			if (!p1_c && !p2_c) begin
				p1_c = 1'b1;
				mv_c = 1'b1;
				mvp_c = HOMING_RUN;
			end else begin
				if (p1_c && sw_q && !run_q) begin
					p2_c = 1'b1;
					mv_c = 1'b1;
					mvp_c = -HOMING_RUN;
				end
				if (p2_c && !sw_q) begin
					stop_c = 1'b1;
					p1_c = 1'b0;
					p2_c = 1'b0;
					mode_c = M_IDLE;
					pos_c = HOME_POS_Q8;
					tgt_c = HOME_TGT_Q8;
				end
			end
		end
		d_c = {pos_c[18], pos_c} - $signed({3'b000, tgt_c});
		if (mode_c == M_PREP) begin
			prep_c = 1'b1;
			mv_c = 1'b1;
			mode_c = d_c[19] ? M_DOWN_OVER : M_UP;
		end else if (mode_c == M_DOWN_OVER && !run_q) begin
			mode_c = M_DOWN_CORR;
			mv_c = 1'b1;
			mvp_c = BACKLASH_PULSES;
		end else if ((mode_c == M_DOWN_CORR || mode_c == M_UP) && !run_q) begin
			mode_c = M_IDLE;
		end
	end

	// move preparation: truncate toward zero, then backlash on downward moves
	logic signed [32:0] trunc_c;
	logic signed [33:0] pp_c;
	always_comb begin
		trunc_c = prod_q[32] ? ((prod_q + 33'sd255) >>> 8) : (prod_q >>> 8);
		pp_c = {trunc_c[32], trunc_c};
		if (d_q[19]) pp_c = pp_c - 34'(BACKLASH_PULSES);
	end

	// position tracking: |left*256| + ppm/2, then divide by ppm
	logic signed [23:0] left_c;
	logic signed [31:0] num_c;
	logic [31:0]       mag_c;
	logic [12:0]       trial_c;
	logic              ge_c;
	logic signed [33:0] qs_c, sum_c;
	always_comb begin
		left_c = mv_q ? mvp_q : dtg_q;
		num_c = {left_c, 8'h00};
		mag_c = num_c[31] ? 32'(-num_c) : 32'(num_c);
		trial_c = {rem_q, dq_q[31]};
		ge_c = trial_c >= {1'b0, ppm_e};
		qs_c = neg_q ? -$signed({2'b00, dq_q}) : $signed({2'b00, dq_q});
		sum_c = $signed({17'd0, tgt_q}) + qs_c;
	end

	always_comb begin
		status.track = mode_q inside {M_UP, M_DOWN_OVER, M_DOWN_CORR};
		status.div_last = div_cnt_q == 5'(DIV_STEPS - 1);
		status.out_busy = out_valid_q && !out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			p1_q <= 1'b0;
			p2_q <= 1'b0;
			prev_q <= 1'b0;
			pos_q <= '0;
			tgt_q <= '0;
			ppm_q <= PPM_RESET;
			out_valid_q <= 1'b0;
			div_cnt_q <= '0;
		end else begin
			if (cfg_valid) ppm_q <= pulses_per_mm;
			if (cw.ctrl) begin
				mode_q <= mode_c;
				p1_q <= p1_c;
				p2_q <= p2_c;
				prev_q <= sw_q;
				pos_q <= pos_c;
				tgt_q <= tgt_c;
			end
			if (cw.div_init) div_cnt_q <= '0;
			else if (cw.div_step) div_cnt_q <= div_cnt_q + 5'd1;
			if (cw.pos) pos_q <= sat19(sum_c);
			if (cw.emit && !status.out_busy) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cw.accept && in_valid) begin
			op_q <= op;
			tgt_in_q <= target_position;
			sw_q <= switch_pressed;
			run_q <= motor_running;
			dtg_q <= distance_to_go;
		end
		if (cw.ctrl) begin
			mv_q <= mv_c;
			mvp_q <= mvp_c;
			stop_q <= stop_c;
			prep_q <= prep_c;
			d_q <= d_c;
		end
		if (cw.mul) prod_q <= d_q * $signed({1'b0, ppm_e});
		if (cw.prep && prep_q) mvp_q <= sat24(pp_c);
		if (cw.div_init) begin
			dq_q <= mag_c + {21'd0, ppm_e[11:1]};
			rem_q <= '0;
			neg_q <= num_c[31];
		end
		if (cw.div_step) begin
			rem_q <= ge_c ? 12'(trial_c - {1'b0, ppm_e}) : trial_c[11:0];
			dq_q <= {dq_q[30:0], ge_c};
		end
		if (cw.emit && !status.out_busy) begin
			move_valid_q <= mv_q;
			move_pulses_q <= mv_q ? mvp_q : 24'sd0;
			stop_out_q <= stop_q;
			p2_out_q <= p2_q;
			mode_out_q <= mode_q;
			pos_out_q <= pos_q;
		end
	end

	assign out_valid = out_valid_q;
	assign move_valid = move_valid_q;
	assign move_pulses = move_pulses_q;
	assign stop_request = stop_out_q;
	assign slow_speed = p2_out_q;
	assign constant_speed = p2_out_q;
	assign machine_mode = mode_out_q;
	assign current_position = pos_out_q;

endmodule

// ----- design/stepper_homing_backlash_sequencer_top.sv -----
// Each beat runs the wait, control, multiply and prep steps of the 8-step
// microprogram, then emit; a tracked position adds div-init, the 1-bit/cycle
// divide loop and the position step before emit, which holds while a result is stalled.
// One beat at a time; a new beat is taken while the previous result still waits.
// Reset: arst_n asynchronous, active low; clears machine state, position and
// target to 0, pulses_per_mm to 400; no clearing pass.
module stepper_homing_backlash_sequencer_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [11:0]        pulses_per_mm,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         op,
	input  logic [16:0]        target_position,
	input  logic               switch_pressed,
	input  logic               motor_running,
	input  logic signed [23:0] distance_to_go,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               move_valid,
	output logic signed [23:0] move_pulses,
	output logic               stop_request,
	output logic               slow_speed,
	output logic               constant_speed,
	output logic [2:0]         machine_mode,
	output logic signed [18:0] current_position
);
	import shbs_pkg::*;

	step_t      step_q;
	ucode_t     cw;
	dp_status_t status;
	logic       taken;

	shbs_ucode_rom u_rom (
		.step(step_q),
		.cw(cw)
	);

	shbs_datapath u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cw(cw),
		.status(status),
		.cfg_valid(cfg_valid),
		.pulses_per_mm(pulses_per_mm),
		.in_valid(in_valid),
		.op(op),
		.target_position(target_position),
		.switch_pressed(switch_pressed),
		.motor_running(motor_running),
		.distance_to_go(distance_to_go),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.move_valid(move_valid),
		.move_pulses(move_pulses),
		.stop_request(stop_request),
		.slow_speed(slow_speed),
		.constant_speed(constant_speed),
		.machine_mode(machine_mode),
		.current_position(current_position)
	);

	always_comb begin
		case (cw.jump)
			J_NONE:     taken = 1'b0;
			J_NO_IN:    taken = !in_valid;
			J_NO_TRACK: taken = !status.track;
			J_DIV_MORE: taken = !status.div_last;
			J_OUT_BUSY: taken = status.out_busy;
			default:    taken = 1'b0;
		endcase
	end

	// step counter wraps from the emit step back to wait
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_WAIT;
		end else begin
			step_q <= taken ? cw.dest : step_q + step_t'(1);
		end
	end

	assign in_ready = cw.accept;
	assign cfg_ready = 1'b1;

endmodule

// ----- design/shbs_checker.sv -----
module shbs_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic               move_valid,
	input logic signed [23:0] move_pulses,
	input logic               slow_speed,
	input logic               constant_speed,
	input logic [2:0]         machine_mode,
	input logic signed [18:0] current_position
);
	import shbs_pkg::*;

	// one beat at a time: an accepted beat closes the input until its result is built
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted on consecutive cycles");

	a_no_move_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !move_valid |-> move_pulses == 24'sd0)
		else $error("move_pulses nonzero without move_valid");

	a_speed_pair: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> slow_speed == constant_speed)
		else $error("slow and constant speed disagree");

	a_slow_only_homing: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && slow_speed |-> machine_mode == M_HOMING)
		else $error("slow speed outside homing");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(move_pulses)
			&& $stable(current_position))
		else $error("result changed while stalled");

endmodule

bind stepper_homing_backlash_sequencer_top shbs_checker u_shbs_checker (.*);
